/* rtl/core/egsa_pkg.sv */
`timescale 1ns / 1ps
package egsa_pkg;

  localparam logic OP_ADD_BIT  = 1'b0;
  localparam logic OP_READ_BIT = 1'b1;

  localparam logic [2:0] REG_RHO = 3'd0;

  localparam logic signed [47:0] GRAM_MAX   = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] GRAM_MIN   = {1'b1, {47{1'b0}}};
  localparam logic signed [63:0] SAND_MAX   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAND_MIN   = {1'b1, {63{1'b0}}};
  localparam logic [23:0]        COUNT_MAX  = 24'hFFFFFF;
  localparam logic signed [47:0] GRAM_ONE   = 48'sd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DIVSTART,
    S_DIV,
    S_PS,
    S_PERT,
    S_ROWHEAD,
    S_DIAG_RD,
    S_DIAG_WR,
    S_PAIR_RD,
    S_PAIR_MUL,
    S_PAIR_WR,
    S_READ_RD,
    S_READ_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -41'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

/* rtl/core/egsa_ram.sv */
`timescale 1ns / 1ps
module egsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/egsa_div.sv */
`timescale 1ns / 1ps
module egsa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  // restoring division, one quotient bit per cycle
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 6'd32;
    end else if (cnt != 6'd0) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != 6'd0) begin
      if (!trial[32]) begin
        rem <= trial;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign busy     = (cnt != 6'd0);
  assign quotient = quo;
endmodule

/* rtl/core/equicorr_gram_sandwich_accumulator.sv */
`timescale 1ns / 1ps
// equicorrelation gram / sandwich accumulator
// input channel (in_valid/in_ready): op 0 buffers an observation (leaf, residual);
// a group_end mark closes the group, op 1 reads one entry of the gram,
// sandwich and count stores, answered by one transfer on the output channel
// (out_valid/out_ready) carrying the sticky overflow flag as well.
// the user writes rho_q15 over the apb port at address 0 only while the block
// is idle; the block does not enforce this. the block takes one item at a time;
// in_ready is low while an item works. an observation without group_end leaves
// the block idle. a read registers its result in S_READ_RD and raises out_valid
// from S_READ_OUT; the next item is taken the cycle after the result transfers.
// closing a group of n: the restoring divider forms phi, then one shared
// 32x32 multiplier walks the n*n pair updates, each a read-modify-write of
// the store memories.
// an empty group returns to idle from S_DIVSTART without starting the divider.
// after reset a clearing pass writes zero to every store entry (4096 entries with
// 64 leaves), zeroing the gram, sandwich and count memories; items are not
// taken meanwhile, apb writes are.
// a stalled output holds its result until transferred; the next item is
// taken only after that.
module equicorr_gram_sandwich_accumulator #(
  parameter int LEAVES    = 64,
  parameter int MAX_GROUP = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [5:0]          leaf_index,
  input  logic signed [23:0]  residual,
  input  logic                group_end,
  input  logic [5:0]          read_row,
  input  logic [5:0]          read_col,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [47:0]  gram_value,
  output logic signed [63:0]  sandwich_value,
  output logic [23:0]         leaf_count,
  output logic                overflow_seen
);
  import egsa_pkg::*;

  localparam int LW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int GW = $clog2(MAX_GROUP);
  localparam int SW = $clog2(MAX_GROUP + 1);
  localparam int AW = 2 * LW;
  localparam int CW = AW + 1;

  // config
  logic [14:0] rho;
  always_ff @(posedge clk) begin
    if (rst) begin
      rho <= '0;
    end else if (psel && penable && pwrite && paddr == REG_RHO) begin
      rho <= pwdata[14:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == REG_RHO) ? {17'd0, rho} : 32'd0;

  state_t state, state_next;

  logic [SW-1:0]        gsize;
  logic signed [31:0]   rsum;
  logic                 ovf;
  logic [CW-1:0]        clr_cnt;
  logic [GW-1:0]        ia, ib;
  logic [LW-1:0]        la, lb;
  logic signed [31:0]   pa;
  logic [15:0]          phi;
  logic signed [31:0]   ps;
  logic signed [63:0]   prod;
  logic                 rd_out_rng;
  logic                 rd_row_rng;
  logic                 out_v;
  logic signed [47:0]   g_q;
  logic signed [63:0]   s_q;
  logic [23:0]          c_q;

  // buffer memories: leaf and residual; pert has a third
  logic                 buf_we;
  logic [GW-1:0]        buf_waddr, buf_raddr;
  logic [LW-1:0]        leaf_rd;
  logic [23:0]          res_rd;
  logic                 pert_we;
  logic [GW-1:0]        pert_waddr, pert_raddr;
  logic [31:0]          pert_wdata, pert_rd;

  egsa_ram #(.WIDTH(LW), .DEPTH(MAX_GROUP)) u_leaf_ram (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(LW'(leaf_index)),
    .raddr(buf_raddr), .rdata(leaf_rd));
  egsa_ram #(.WIDTH(24), .DEPTH(MAX_GROUP)) u_res_ram (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(residual),
    .raddr(buf_raddr), .rdata(res_rd));
  egsa_ram #(.WIDTH(32), .DEPTH(MAX_GROUP)) u_pert_ram (
    .clk(clk), .we(pert_we), .waddr(pert_waddr), .wdata(pert_wdata),
    .raddr(pert_raddr), .rdata(pert_rd));

  // store memories
  logic              st_we;
  logic [AW-1:0]     st_waddr, st_raddr;
  logic [47:0]       g_wdata, g_rd;
  logic [63:0]       s_wdata, s_rd;

  egsa_ram #(.WIDTH(48), .DEPTH(1 << AW)) u_gram_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(g_wdata),
    .raddr(st_raddr), .rdata(g_rd));
  egsa_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_sand_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(s_wdata),
    .raddr(st_raddr), .rdata(s_rd));

  // per-leaf observation counts
  logic              cnt_we;
  logic [LW-1:0]     cnt_waddr, cnt_raddr;
  logic [23:0]       cnt_wdata, cnt_rd;

  egsa_ram #(.WIDTH(24), .DEPTH(1 << LW)) u_count_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rd));

  // divider
  logic        div_start, div_busy;
  logic [31:0] div_q;
  logic [31:0] den;
  egsa_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({1'b0, rho, 16'd0} + {1'b0, den[31:1]}),
    .divisor(den), .busy(div_busy), .quotient(div_q));
  assign den = 32'd32768 + 32'(gsize - SW'(1)) * 32'(rho);

  logic in_fire, is_add;
  assign in_fire = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !out_v;
  assign is_add   = (op == OP_ADD_BIT);

  logic signed [63:0] phi_sum;
  assign phi_sum = $signed({1'b0, div_q[15:0]}) * rsum;

  logic empty_group;
  assign empty_group = (gsize == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (clr_cnt == CW'((1 << AW) - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (!is_add) state_next = S_READ_RD;
          else if (group_end) state_next = S_DIVSTART;
        end
      end
      S_DIVSTART: state_next = empty_group ? S_IDLE : S_DIV;
      S_DIV:      if (!div_busy) state_next = S_PS;
      S_PS:       state_next = S_PERT;
      S_PERT:     if (ib == GW'(gsize - SW'(1)) && ia == GW'(gsize - SW'(1)))
                    state_next = S_ROWHEAD;
      S_ROWHEAD:  state_next = S_DIAG_RD;
      S_DIAG_RD:  state_next = S_DIAG_WR;
      S_DIAG_WR:  state_next = S_PAIR_RD;
      S_PAIR_RD:  state_next = S_PAIR_MUL;
      S_PAIR_MUL: state_next = S_PAIR_WR;
      S_PAIR_WR: begin
        if (SW'(ib) + SW'(1) < gsize) state_next = S_PAIR_RD;
        else if (SW'(ia) + SW'(1) < gsize) state_next = S_ROWHEAD;
        else state_next = S_IDLE;
      end
      S_READ_RD:  state_next = S_READ_OUT;
      S_READ_OUT: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_start  = 1'b0;
    buf_we     = 1'b0;
    buf_waddr  = GW'(gsize);
    buf_raddr  = ib;
    pert_we    = 1'b0;
    pert_waddr = ia;
    pert_raddr = ib;
    pert_wdata = sat32(41'($signed(res_rd)) - 41'(ps));
    st_we      = 1'b0;
    st_waddr   = {la, lb};
    st_raddr   = {la, lb};
    g_wdata    = '0;
    s_wdata    = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = la;
    cnt_raddr  = la;
    cnt_wdata  = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 24'd1;
    unique case (state)
      S_CLEAR: begin
        st_we     = 1'b1;
        st_waddr  = clr_cnt[AW-1:0];
        cnt_we    = 1'b1;
        cnt_waddr = clr_cnt[LW-1:0];
        cnt_wdata = '0;
      end
      S_IDLE: begin
        buf_we = in_fire && is_add && ({26'd0, leaf_index} < 32'(LEAVES))
                 && (gsize < SW'(MAX_GROUP));
        st_raddr  = {LW'(read_row), LW'(read_col)};
        cnt_raddr = LW'(read_row);
      end
      S_DIVSTART: div_start = !empty_group;
      S_PERT: begin
        buf_raddr = ib;
        pert_we   = 1'b1;
      end
      S_ROWHEAD: begin
        buf_raddr = ia;
        pert_raddr = ia;
      end
      S_DIAG_RD: begin
        st_raddr  = {leaf_rd, leaf_rd};
        cnt_raddr = leaf_rd;
      end
      S_DIAG_WR: begin
        st_we    = 1'b1;
        st_waddr = {la, la};
        g_wdata  = ($signed(g_rd) > GRAM_MAX - GRAM_ONE)
                   ? GRAM_MAX : $signed(g_rd) + GRAM_ONE;
        s_wdata  = s_rd;
        cnt_we   = 1'b1;
        buf_raddr = ib;
        pert_raddr = ib;
      end
      S_PAIR_RD: begin
        st_raddr = {la, leaf_rd};
      end
      S_PAIR_MUL: ;
      S_PAIR_WR: begin
        st_we    = 1'b1;
        g_wdata  = ($signed(g_rd) < GRAM_MIN + $signed({32'd0, phi}))
                   ? GRAM_MIN : $signed(g_rd) - $signed({32'd0, phi});
        if (prod > 0 && $signed(s_rd) > SAND_MAX - prod) s_wdata = SAND_MAX;
        else if (prod < 0 && $signed(s_rd) < SAND_MIN - prod) s_wdata = SAND_MIN;
        else s_wdata = $signed(s_rd) + prod;
        buf_raddr  = GW'(SW'(ib) + SW'(1));
        pert_raddr = GW'(SW'(ib) + SW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      gsize   <= '0;
      rsum    <= '0;
      ovf     <= 1'b0;
      out_v   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_v && out_ready) out_v <= 1'b0;
      unique case (state)
        S_CLEAR: clr_cnt <= clr_cnt + CW'(1);
        S_IDLE: begin
          if (in_fire && is_add) begin
            if ({26'd0, leaf_index} < 32'(LEAVES)) begin
              if (gsize < SW'(MAX_GROUP)) begin
                gsize <= gsize + SW'(1);
                rsum  <= sat32(41'(rsum) + 41'(residual));
              end else begin
                ovf <= 1'b1;
              end
            end
          end
        end
        S_PAIR_WR: begin
          if (state_next == S_IDLE) begin
            gsize <= '0;
            rsum  <= '0;
          end
        end
        S_READ_OUT: out_v <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ia <= '0;
        ib <= '0;
        rd_out_rng <= ({26'd0, read_row} >= 32'(LEAVES)) || ({26'd0, read_col} >= 32'(LEAVES));
        rd_row_rng <= ({26'd0, read_row} >= 32'(LEAVES));
      end
      S_PS: begin
        phi <= div_q[15:0];
        ps  <= 32'((phi_sum + 64'sd32768) >>> 16);
        ib  <= '0;
      end
      S_PERT: begin
        // pipeline: address ib issued, result of ib-1 written via ia
        if (state_next == S_ROWHEAD) begin
          ia <= '0;
          ib <= '0;
        end else begin
          ia <= ib;
          if (SW'(ib) + SW'(1) < gsize) ib <= ib + GW'(1);
        end
      end
      S_ROWHEAD: ib <= '0;
      S_DIAG_RD: begin
        la <= leaf_rd;
        pa <= pert_rd;
      end
      S_PAIR_RD: lb <= leaf_rd;
      S_PAIR_MUL: begin
        prod <= 64'(pa) * 64'($signed(pert_rd));
      end
      S_PAIR_WR: begin
        if (SW'(ib) + SW'(1) < gsize) ib <= ib + GW'(1);
        else ia <= ia + GW'(1);
      end
      S_READ_RD: begin
        g_q <= rd_out_rng ? '0 : $signed(g_rd);
        s_q <= rd_out_rng ? '0 : $signed(s_rd);
        c_q <= rd_row_rng ? '0 : cnt_rd;
      end
      default: ;
    endcase
  end

  assign out_valid      = out_v;
  assign gram_value     = g_q;
  assign sandwich_value = s_q;
  assign leaf_count     = c_q;
  assign overflow_seen  = ovf;

  a_no_take_pending: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_v)) else $error("item taken while result pending");
  a_busy_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready) else $error("ready during clear");
  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    gsize <= SW'(MAX_GROUP)) else $error("group size overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_ready |=> out_v) else $error("result dropped");
endmodule
